FILE: rtl/core/handle_pool_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle pool allocator
// Shorthand for clocked concurrent checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HANDLE_POOL_ALLOCATOR_ASSERT_SVH
`define HANDLE_POOL_ALLOCATOR_ASSERT_SVH

// condition holds at every clock edge
`define HPA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HPA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define HPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/hpa_pkg.sv
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared constants, codes and helpers of the handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

   localparam int POOL_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(POOL_DEPTH);
   localparam int HANDLE_W   = 10;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } hpa_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_NOT_LIVE = 2'd3
   } hpa_status_type;

   // limit a written capacity to 1..POOL_DEPTH
   function automatic logic [COUNT_W-1:0] clamp_capacity(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = COUNT_W'(1);
      end else if (value > COUNT_W'(POOL_DEPTH)) begin
         result = COUNT_W'(POOL_DEPTH);
      end
      return result;
   endfunction

endpackage

FILE: rtl/core/hpa_ram.sv
// ----------------------------------------------------------------------------
// hpa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hpa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/handle_pool_allocator.sv
// ----------------------------------------------------------------------------
// handle_pool_allocator
// Response: a request's response is registered from ST_READ once the table reads
//   return; ST_READ waits while the response register is still held by the receiver.
// Sequence: allocate and any rejected request pass ST_IDLE and ST_READ, a
//   successful free also ST_SWAP, set by the single write port of each table
//   memory (two entries of each table change on a free); one request at a time.
// Reset and each capacity write start a clearing pass over all POOL_DEPTH
//   entries that loads identity into both tables; no request is taken meanwhile.
// ----------------------------------------------------------------------------
`include "handle_pool_allocator_assert.svh"

module handle_pool_allocator (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hpa_pkg::REQ_DATA_W-1:0] req_tdata,  // [9:0] handle_in, [15:10] zero
   input  logic                           req_tuser,  // [0] command
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hpa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [9:0] handle_out, [11:10] status,
                                                      // [22:12] live_count, [23] zero
   // capacity register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hpa_pkg::COUNT_W-1:0]    csr_data    // capacity
);

   import hpa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,   // waiting for a request, reads issued on accept
      ST_READ = 3'b010,   // table words back: decide, respond, first writes
      ST_SWAP = 3'b100    // second writes of a successful free
   } hpa_state_type;

   hpa_state_type        state_ff, state_in;
   hpa_cmd_type          cmd_ff, cmd_in;
   logic [ADDR_W-1:0]    handle_ff, handle_in;
   logic [COUNT_W-1:0]   live_total_ff, live_total_in;
   logic [COUNT_W-1:0]   capacity_ff, capacity_in;
   logic                 clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 csr_accept;
   logic                 out_free;
   logic                 rsp_load;
   logic                 free_ok;
   hpa_status_type       status;
   logic [HANDLE_W-1:0]  handle_out;

   // memory ports
   logic                 ord_we, ord_re, pos_we, pos_re;
   logic [ADDR_W-1:0]    ord_waddr, ord_raddr, pos_waddr, pos_raddr;
   logic [ADDR_W-1:0]    ord_wdata, pos_wdata, ord_rdata, pos_rdata;
   logic [ADDR_W-1:0]    last_pos;

   // check helpers
   logic                 alloc_ok;
   logic [COUNT_W-1:0]   live_plus_one;

   // ------------------------------------------------------------------------
   // Handshakes: a capacity write wins over a request in the same cycle
   // ------------------------------------------------------------------------
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_accept = csr_valid && csr_ready;
   assign req_tready = (state_ff == ST_IDLE) && !clr_busy_ff && !csr_valid;
   assign req_accept = req_tvalid && req_tready;

   // output register may take a new response when empty or draining now
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = (state_ff == ST_READ) && out_free;

   // ------------------------------------------------------------------------
   // Decide the outcome from the returned table words
   //   ord_rdata: order_table[live] for allocate, order_table[live-1] for free
   //   pos_rdata: position_table[handle]
   // ------------------------------------------------------------------------
   always_comb begin
      status     = STATUS_OK;
      handle_out = '0;
      free_ok    = 1'b0;
      if (cmd_ff == CMD_ALLOC) begin
         if (live_total_ff >= capacity_ff) begin
            status = STATUS_FULL;
         end else begin
            handle_out = HANDLE_W'(ord_rdata);
         end
      end else begin
         if (COUNT_W'(handle_ff) >= capacity_ff) begin
            status = STATUS_RANGE;
         end else if (COUNT_W'(pos_rdata) >= live_total_ff) begin
            status = STATUS_NOT_LIVE;
         end else begin
            free_ok = 1'b1;
         end
      end
   end

   // in ST_SWAP the count already holds the old last position
   assign last_pos = live_total_ff[ADDR_W-1:0];

   // ------------------------------------------------------------------------
   // Table memory ports; the clearing pass owns the write ports while busy
   // ------------------------------------------------------------------------
   always_comb begin
      ord_re    = req_accept;
      pos_re    = req_accept;
      pos_raddr = ADDR_W'(req_tdata[HANDLE_W-1:0]);
      if (hpa_cmd_type'(req_tuser) == CMD_ALLOC) begin
         ord_raddr = live_total_ff[ADDR_W-1:0];
      end else begin
         ord_raddr = ADDR_W'(live_total_ff - COUNT_W'(1));
      end

      ord_we    = 1'b0;
      ord_waddr = clr_addr_ff;
      ord_wdata = clr_addr_ff;
      pos_we    = 1'b0;
      pos_waddr = clr_addr_ff;
      pos_wdata = clr_addr_ff;
      if (clr_busy_ff) begin
         ord_we = 1'b1;
         pos_we = 1'b1;
      end else if (state_ff == ST_READ && rsp_load && free_ok) begin
         // move the last live handle into the freed slot
         ord_we    = 1'b1;
         ord_waddr = pos_rdata;
         ord_wdata = ord_rdata;
         pos_we    = 1'b1;
         pos_waddr = ord_rdata;
         pos_wdata = pos_rdata;
      end else if (state_ff == ST_SWAP) begin
         // park the freed handle at the old last position
         ord_we    = 1'b1;
         ord_waddr = last_pos;
         ord_wdata = handle_ff;
         pos_we    = 1'b1;
         pos_waddr = handle_ff;
         pos_wdata = last_pos;
      end
   end

   hpa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (POOL_DEPTH)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_en   (ord_re),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   hpa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (POOL_DEPTH)
   ) u_position_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_en   (pos_re),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   // ------------------------------------------------------------------------
   // Sequencer, count, clearing pass and response register
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      live_total_in = live_total_ff;
      capacity_in   = capacity_ff;
      clr_busy_in   = clr_busy_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      // advance the clearing pass
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(POOL_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_accept) begin
               // reinitialise: restart the pass, drop all live handles
               capacity_in   = clamp_capacity(csr_data);
               live_total_in = '0;
               clr_busy_in   = 1'b1;
               clr_addr_in   = '0;
            end else if (req_accept) begin
               cmd_in    = hpa_cmd_type'(req_tuser);
               handle_in = ADDR_W'(req_tdata[HANDLE_W-1:0]);
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // hold here with the read words stable until the output frees
            if (rsp_load) begin
               state_in = ST_IDLE;
               if (cmd_ff == CMD_ALLOC && status == STATUS_OK) begin
                  live_total_in = live_total_ff + COUNT_W'(1);
               end else if (free_ok) begin
                  live_total_in = live_total_ff - COUNT_W'(1);
                  state_in      = ST_SWAP;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, live_total_in, status, handle_out};
            end
         end
         ST_SWAP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_total_ff <= '0;
         capacity_ff   <= clamp_capacity(COUNT_W'(POOL_DEPTH));
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_total_ff <= live_total_in;
         capacity_ff   <= capacity_in;
         clr_busy_ff   <= clr_busy_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      handle_ff   <= handle_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   assign alloc_ok      = rsp_load && cmd_ff == CMD_ALLOC && status == STATUS_OK;
   assign live_plus_one = live_total_ff + COUNT_W'(1);

   `HPA_ASSERT_ALWAYS(a_live_within_cap, live_total_ff <= capacity_ff, "count above capacity")
   `HPA_ASSERT_SAME(a_clear_only_idle, clr_busy_ff, state_ff == ST_IDLE, "clearing outside idle")
   `HPA_ASSERT_SAME(a_swap_order, state_ff == ST_SWAP, $past(state_ff) == ST_READ, "stray swap")
   `HPA_ASSERT_NEXT(a_alloc_up, alloc_ok, live_total_ff == $past(live_plus_one), "no count up")

endmodule
